// ===== hdl/tcw_pkg.sv =====
// tcw_pkg: screen geometry, cell encodings, operation codes and sequencer states
// for the text console writer
// no dependencies
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   // field widths
   localparam int ADDR_W = 11;
   localparam int CELL_W = 16;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 8;

   // character codes
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_BLANK     = 8'h20;
   localparam logic [BYTE_W-1:0] ATTR_BLACK     = 8'h00;
   localparam logic [CELL_W-1:0] BLANK_CELL     = {ATTR_BLACK, CHAR_BLANK};

   // cursor arithmetic constants
   localparam logic [ADDR_W-1:0] COLUMNS_A        = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL        = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW_START   = ADDR_W'(CELL_COUNT - COLUMNS);
   localparam logic [ADDR_W-1:0] CELL_COUNT_A     = ADDR_W'(CELL_COUNT);
   localparam logic [POS_W-1:0]  LAST_COL         = POS_W'(COLUMNS - 1);
   localparam logic [POS_W-1:0]  LAST_ROW         = POS_W'(ROWS - 1);

   // operation codes
   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_COPY,
      ST_FILL,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/tcw_ram.sv =====
// tcw_ram: generic single write port, single read port ram with registered read
// no dependencies
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/text_console_writer_core.sv =====
// text_console_writer_core: text screen store with cursor, put/read/clear sequencer
// depends on tcw_pkg and tcw_ram
//
// Usage: one beat on the req_ channel carries an operation (put character,
// read cell, clear screen) with its character, color and cell address. Each
// request beat yields exactly one rsp_ beat with the cell read (zero for
// other operations), the cursor after the operation and a scroll flag.
// Only one request is in flight: req_stall is high from acceptance until
// the response is loaded into the output register. From the request beat
// the sequencer goes through EXEC and DONE for a put without scroll, an
// unused code or a read past the last cell, through EXEC, READ and DONE
// for a read in range, through EXEC, COPY, FILL and DONE for a put that
// scrolls (the copy of every row up one and the blank fill of the bottom
// row go one cell a cycle through the single ram port pair), and through
// EXEC, FILL and DONE for a clear, which walks the whole store one cell a
// cycle. The next request can be taken while the previous response is shown.
// After reset the block runs a clearing pass over all CELL_COUNT (2000)
// cells with req_stall high, then accepts requests with the cursor home.
// A response held by rsp_stall stays in the output register; the next
// request is still accepted and processed, and its response waits for the
// register to free up.
module text_console_writer_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_op,
   input  logic [tcw_pkg::BYTE_W-1:0]  req_char_code,
   input  logic [tcw_pkg::BYTE_W-1:0]  req_color,
   input  logic [tcw_pkg::ADDR_W-1:0]  req_cell_address,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tcw_pkg::CELL_W-1:0]  rsp_cell_data,
   output logic [tcw_pkg::ADDR_W-1:0]  rsp_cursor_position,
   output logic                        rsp_scrolled
);
   import tcw_pkg::*;

   state_type state_ff, state_in;

   logic [1:0]        op_ff, op_in;
   logic [BYTE_W-1:0] char_ff, char_in;
   logic [BYTE_W-1:0] color_ff, color_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [POS_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [CELL_W-1:0] fill_ff, fill_in;
   logic [CELL_W-1:0] data_res_ff, data_res_in;
   logic              scroll_res_ff, scroll_res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_data_ff, rsp_data_in;
   logic [ADDR_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic              rsp_scroll_ff, rsp_scroll_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [CELL_W-1:0] mem_wd;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_ra;
   logic [CELL_W-1:0] mem_rd;

   logic is_nl;
   logic is_bs;
   logic put_scroll;
   logic addr_ok;
   logic out_free;

   // screen cell store
   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   // decode of the held request
   assign is_nl      = (char_ff == CHAR_NEWLINE);
   assign is_bs      = (char_ff == CHAR_BACKSPACE);
   assign put_scroll = (row_ff == LAST_ROW) && (is_nl || (!is_bs && col_ff == LAST_COL));
   assign addr_ok    = (addr_ff < CELL_COUNT_A);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (idx_ff == LAST_CELL) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_PUT:   state_in = put_scroll ? ST_COPY : ST_DONE;
               OP_READ:  state_in = addr_ok ? ST_READ : ST_DONE;
               OP_CLEAR: state_in = ST_FILL;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_COPY: begin
            if (idx_ff == LAST_ROW_START) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (idx_ff == LAST_CELL) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // datapath, store access and response loading
   always_comb begin
      op_in         = op_ff;
      char_in       = char_ff;
      color_in      = color_ff;
      addr_in       = addr_ff;
      cursor_in     = cursor_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      idx_in        = idx_ff;
      wr_pend_in    = wr_pend_ff;
      wr_addr_in    = wr_addr_ff;
      fill_in       = fill_ff;
      data_res_in   = data_res_ff;
      scroll_res_in = scroll_res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_scroll_in = rsp_scroll_ff;
      mem_we        = 1'b0;
      mem_wa        = idx_ff;
      mem_wd        = fill_ff;
      mem_re        = 1'b0;
      mem_ra        = addr_ff;
      req_stall     = (state_ff != ST_IDLE);

      case (state_ff)
         // clearing pass after reset
         ST_INIT: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = BLANK_CELL;
            idx_in = idx_ff + ADDR_W'(1);
         end
         // capture request beat
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               char_in       = req_char_code;
               color_in      = req_color;
               addr_in       = req_cell_address;
               data_res_in   = '0;
               scroll_res_in = 1'b0;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_PUT: begin
                  if (is_nl) begin
                     cursor_in = cursor_ff + (COLUMNS_A - ADDR_W'(col_ff));
                     col_in    = '0;
                     row_in    = row_ff + POS_W'(1);
                  end else if (is_bs) begin
                     if (cursor_ff != '0) begin
                        cursor_in = cursor_ff - ADDR_W'(1);
                        mem_we    = 1'b1;
                        mem_wa    = cursor_ff - ADDR_W'(1);
                        mem_wd    = {color_ff, CHAR_BLANK};
                        if (col_ff == '0) begin
                           col_in = LAST_COL;
                           row_in = row_ff - POS_W'(1);
                        end else begin
                           col_in = col_ff - POS_W'(1);
                        end
                     end
                  end else begin
                     mem_we    = 1'b1;
                     mem_wa    = cursor_ff;
                     mem_wd    = {color_ff, char_ff};
                     cursor_in = cursor_ff + ADDR_W'(1);
                     if (col_ff == LAST_COL) begin
                        col_in = '0;
                        row_in = row_ff + POS_W'(1);
                     end else begin
                        col_in = col_ff + POS_W'(1);
                     end
                  end
                  // run past the last cell: start the scroll
                  if (put_scroll) begin
                     cursor_in     = LAST_ROW_START;
                     col_in        = '0;
                     row_in        = LAST_ROW;
                     scroll_res_in = 1'b1;
                     idx_in        = '0;
                     wr_pend_in    = 1'b0;
                     fill_in       = {color_ff, CHAR_BLANK};
                  end
               end
               OP_READ: begin
                  if (addr_ok) begin
                     mem_re = 1'b1;
                     mem_ra = addr_ff;
                  end
               end
               OP_CLEAR: begin
                  cursor_in = '0;
                  col_in    = '0;
                  row_in    = '0;
                  idx_in    = '0;
                  fill_in   = BLANK_CELL;
               end
               default: begin
               end
            endcase
         end
         // read data arrives from the store
         ST_READ: begin
            data_res_in = mem_rd;
         end
         // row move: read one row below, write back the previous read
         ST_COPY: begin
            if (wr_pend_ff) begin
               mem_we = 1'b1;
               mem_wa = wr_addr_ff;
               mem_wd = mem_rd;
            end
            if (idx_ff != LAST_ROW_START) begin
               mem_re     = 1'b1;
               mem_ra     = idx_ff + COLUMNS_A;
               wr_pend_in = 1'b1;
               wr_addr_in = idx_ff;
               idx_in     = idx_ff + ADDR_W'(1);
            end else begin
               wr_pend_in = 1'b0;
            end
         end
         // blank fill up to the last cell
         ST_FILL: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = fill_ff;
            idx_in = idx_ff + ADDR_W'(1);
         end
         // hand the result to the output register
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = data_res_ff;
               rsp_cursor_in = cursor_ff;
               rsp_scroll_in = scroll_res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         cursor_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         wr_pend_ff   <= wr_pend_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      char_ff       <= char_in;
      color_ff      <= color_in;
      addr_ff       <= addr_in;
      wr_addr_ff    <= wr_addr_in;
      fill_ff       <= fill_in;
      data_res_ff   <= data_res_in;
      scroll_res_ff <= scroll_res_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_data       = rsp_data_ff;
   assign rsp_cursor_position = rsp_cursor_ff;
   assign rsp_scrolled        = rsp_scroll_ff;

endmodule
